// ===== rtl/ccrc16_pkg.sv =====
// Package with the shared types, register indexes and CRC helper functions.
package ccrc16_pkg;

    localparam int REG_WIDTH = 16;

    typedef logic [2:0]           t_cfg_index;
    typedef logic [REG_WIDTH-1:0] t_crc;

    localparam t_cfg_index CFG_CRC_WIDTH    = 3'd0;
    localparam t_cfg_index CFG_POLY         = 3'd1;
    localparam t_cfg_index CFG_INIT_VALUE   = 3'd2;
    localparam t_cfg_index CFG_XOR_OUT      = 3'd3;
    localparam t_cfg_index CFG_REFLECT_IN   = 3'd4;
    localparam t_cfg_index CFG_REFLECT_OUT  = 3'd5;
    localparam t_cfg_index CFG_GRADUAL_MODE = 3'd6;

    function automatic t_crc f_rev16(t_crc v);
        t_crc r;
        for (int i = 0; i < REG_WIDTH; i++) begin
            r[i] = v[REG_WIDTH-1-i];
        end
        return r;
    endfunction

    function automatic logic [7:0] f_rev8(logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    // Widths below one act as one and widths above the register act as full width.
    function automatic logic [3:0] f_align_shift(logic [4:0] width);
        logic [3:0] sh;
        if (width == 5'd0) begin
            sh = 4'(REG_WIDTH - 1);
        end else if (width >= 5'(REG_WIDTH)) begin
            sh = 4'd0;
        end else begin
            sh = 4'(5'(REG_WIDTH) - width);
        end
        return sh;
    endfunction

    // One byte of MSB-first update with the polynomial aligned to the top.
    function automatic t_crc f_crc_byte(t_crc crc_in, logic [7:0] data, t_crc poly);
        t_crc c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[REG_WIDTH-1]) begin
                c = {c[REG_WIDTH-2:0], 1'b0} ^ poly;
            end else begin
                c = {c[REG_WIDTH-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/configurable_crc_up_to_16.sv =====
// Byte-serial CRC engine with a configurable width of 1 to 16 bits.
// The last byte of a message is held in the input stage register; its result is registered when that stage advances.
// Throughput: one byte per cycle; input stalls only while a finished result is not taken.
// The rate is set by the combinational unrolled 8-bit update between input and result registers.
// Reset is synchronous and active low; it restores the default configuration and clears the CRC.
module configurable_crc_up_to_16 (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  ccrc16_pkg::t_cfg_index i_cfg_index,
    input  logic [15:0]            i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_first,
    input  logic                   i_last,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [15:0]            o_crc_value
);
    import ccrc16_pkg::*;

    logic [4:0] r_crc_width;
    t_crc       r_poly;
    t_crc       r_init_value;
    t_crc       r_xor_out;
    logic       r_reflect_in;
    logic       r_reflect_out;
    logic       r_gradual_mode;

    t_crc       r_crc;
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_first;
    logic       r_s1_last;
    logic       r_out_valid;
    t_crc       r_out_crc;

    logic       s1_advance;
    logic [3:0] sh;
    t_crc       poly_aligned;
    t_crc       crc_start;
    logic [7:0] data_in;
    t_crc       n_crc;
    t_crc       n_out_crc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_width    <= 5'd16;
            r_poly         <= 16'h1021;
            r_init_value   <= '0;
            r_xor_out      <= '0;
            r_reflect_in   <= 1'b0;
            r_reflect_out  <= 1'b0;
            r_gradual_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CRC_WIDTH:    r_crc_width    <= i_cfg_data[4:0];
                CFG_POLY:         r_poly         <= i_cfg_data;
                CFG_INIT_VALUE:   r_init_value   <= i_cfg_data;
                CFG_XOR_OUT:      r_xor_out      <= i_cfg_data;
                CFG_REFLECT_IN:   r_reflect_in   <= i_cfg_data[0];
                CFG_REFLECT_OUT:  r_reflect_out  <= i_cfg_data[0];
                CFG_GRADUAL_MODE: r_gradual_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // A byte without the last mark always moves on; a last byte waits for a free result slot.
    assign s1_advance = r_s1_valid && (!r_s1_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_advance;

    always_comb begin
        sh           = f_align_shift(r_crc_width);
        poly_aligned = r_poly << sh;
        if (!r_s1_first) begin
            crc_start = r_crc;
        end else if (r_reflect_out && r_gradual_mode) begin
            crc_start = f_rev16(r_init_value);
        end else begin
            crc_start = r_init_value << sh;
        end
        data_in = r_reflect_in ? f_rev8(r_s1_byte) : r_s1_byte;
        n_crc   = f_crc_byte(crc_start, data_in, poly_aligned);
        if (r_reflect_out) begin
            n_out_crc = f_rev16(n_crc) ^ r_xor_out;
        end else if (!r_reflect_in) begin
            n_out_crc = (n_crc >> sh) ^ r_xor_out;
        end else begin
            n_out_crc = n_crc ^ r_xor_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_crc       <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_crc <= n_crc;
            end
            if (s1_advance && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_byte  <= i_data_byte;
            r_s1_first <= i_first;
            r_s1_last  <= i_last;
        end
        if (s1_advance && r_s1_last) begin
            r_out_crc <= n_out_crc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_crc_value = r_out_crc;

endmodule

// ===== rtl/ccrc16_checker.sv =====
// Port-level checker for the CRC engine and its bind to the top level.
module ccrc16_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_crc_value
);

    // A stalled result beat keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_crc_value))
        else $error("result beat changed while stalled");

    // A new result must be preceded by an accepted last byte.
    a_rose_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_last, 2))
        else $error("result appeared without a last byte");

    // Reset empties the result slot.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // With the result slot free, the engine always takes a byte.
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid && $past(!i_out_valid) && $past(i_rst_n) |-> i_in_ready)
        else $error("input stalled with an empty result slot");

endmodule

bind configurable_crc_up_to_16 ccrc16_checker u_ccrc16_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_last      (i_last),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_crc_value (o_crc_value)
);
